// ===== rtl/avcc_pse_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package avcc_pse_pkg;

   // Record layout
   localparam logic [7:0]  AVCC_VERSION      = 8'h01;
   localparam logic [7:0]  SPS_COUNT_MASK    = 8'h1F;
   localparam logic [15:0] MIN_RECORD_BYTES  = 16'd7;
   localparam logic [15:0] HEADER_LAST_POS   = 16'd4;
   localparam logic [15:0] POSITION_MAX      = 16'hFFFF;

   // Start code: three zero bytes, then this one
   localparam logic [7:0]  START_CODE_TAIL   = 8'h01;
   localparam int          START_CODE_BYTES  = 4;
   localparam logic [2:0]  START_CODE_LAST   = 3'(START_CODE_BYTES - 1);

   // Unit kinds
   localparam logic KIND_SPS = 1'b0;
   localparam logic KIND_PPS = 1'b1;

   // Record status codes
   localparam logic [1:0] STATUS_UNITS_FOUND = 2'd0;
   localparam logic [1:0] STATUS_NONE_FOUND  = 2'd1;
   localparam logic [1:0] STATUS_NOT_AVCC    = 2'd2;
   localparam logic [1:0] STATUS_TOO_SHORT   = 2'd3;

   typedef enum logic [3:0] {
      PH_HEADER,
      PH_SPS_CNT,
      PH_SPS_HI,
      PH_SPS_LO,
      PH_SPS_PAY,
      PH_PPS_CNT,
      PH_PPS_HI,
      PH_PPS_LO,
      PH_PPS_PAY,
      PH_DONE,
      PH_REJECT
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       unit_kind;
      logic       unit_start;
      logic       unit_end;
      logic       record_done;
      logic [1:0] status;
   } rsp_type;

   // Result items raised by one input byte: a start code or one payload
   // byte, optionally followed by the record status.
   typedef struct packed {
      logic [2:0] nitems;
      logic       kind;
      logic       sc_en;
      logic       sc_end;
      logic       pay_en;
      logic [7:0] pay_byte;
      logic       pay_end;
      logic       done_en;
      logic [1:0] status;
   } burst_type;

endpackage

`default_nettype wire

// ===== rtl/avcc_pse_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module avcc_pse_parser (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept,
   input  wire avcc_pse_pkg::req_type  req_data,
   input  wire logic [15:0]            record_bytes,
   output avcc_pse_pkg::burst_type     burst
);
   import avcc_pse_pkg::*;

   logic [15:0] pos_ff, pos_in;
   phase_type   phase_ff, phase_in, phase_upd;
   logic [7:0]  units_ff, units_in, units_upd;
   logic [7:0]  len_hi_ff, len_hi_in, len_hi_upd;
   logic [15:0] pay_left_ff, pay_left_in, pay_left_upd;
   logic        seen_ff, seen_in, seen_upd;
   logic [1:0]  rstatus_ff, rstatus_in, rstatus_upd;

   logic [7:0]  b;
   logic        in_range;
   logic [16:0] off;
   logic [15:0] len;
   logic        len_over;
   logic [15:0] pay_dec;
   logic [7:0]  units_dec;
   logic        far_end;
   phase_type   sps_leave;
   logic        unit_kind;
   logic        opens_unit;
   logic        in_payload;

   assign b         = req_data.data_byte;
   assign in_range  = pos_ff < record_bytes;
   assign off       = {1'b0, pos_ff} + 17'd1;
   assign len       = {len_hi_ff, b};
   assign len_over  = ({1'b0, off} + {2'b0, len}) > {2'b0, record_bytes};
   assign pay_dec   = pay_left_ff - 16'd1;
   assign units_dec = units_ff - 8'd1;
   assign far_end   = ({1'b0, off} + 18'd2) > {2'b0, record_bytes};
   assign sps_leave = (off >= {1'b0, record_bytes}) ? PH_DONE : PH_PPS_CNT;
   assign unit_kind = (phase_ff == PH_PPS_LO) || (phase_ff == PH_PPS_PAY);
   assign opens_unit = in_range && !len_over &&
                       ((phase_ff == PH_SPS_LO) || (phase_ff == PH_PPS_LO));
   assign in_payload = in_range &&
                       ((phase_ff == PH_SPS_PAY) || (phase_ff == PH_PPS_PAY));

   // Top of the unit loop: leave it when no units remain or no length fits
   function automatic phase_type loop_top(input logic kind, input logic [7:0] units,
                                          input logic far, input phase_type leave);
      phase_type ph;
      if (units == 8'd0 || far) begin
         ph = kind ? PH_DONE : leave;
      end else begin
         ph = kind ? PH_PPS_HI : PH_SPS_HI;
      end
      return ph;
   endfunction

   // Next state
   always_comb begin
      phase_upd    = phase_ff;
      units_upd    = units_ff;
      len_hi_upd   = len_hi_ff;
      pay_left_upd = pay_left_ff;
      seen_upd     = seen_ff;
      rstatus_upd  = rstatus_ff;

      if (in_range) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (pos_ff == 16'd0 && record_bytes < MIN_RECORD_BYTES) begin
                  rstatus_upd = STATUS_TOO_SHORT;
                  phase_upd   = PH_REJECT;
               end else if (pos_ff == 16'd0 && b != AVCC_VERSION) begin
                  rstatus_upd = STATUS_NOT_AVCC;
                  phase_upd   = PH_REJECT;
               end else if (pos_ff >= HEADER_LAST_POS) begin
                  phase_upd = PH_SPS_CNT;
               end
            end
            PH_SPS_CNT: begin
               units_upd = b & SPS_COUNT_MASK;
               phase_upd = loop_top(KIND_SPS, b & SPS_COUNT_MASK, far_end, sps_leave);
            end
            PH_PPS_CNT: begin
               units_upd = b;
               phase_upd = loop_top(KIND_PPS, b, far_end, sps_leave);
            end
            PH_SPS_HI: begin
               len_hi_upd = b;
               phase_upd  = PH_SPS_LO;
            end
            PH_PPS_HI: begin
               len_hi_upd = b;
               phase_upd  = PH_PPS_LO;
            end
            PH_SPS_LO, PH_PPS_LO: begin
               if (len_over) begin
                  phase_upd = unit_kind ? PH_DONE : sps_leave;
               end else begin
                  seen_upd = 1'b1;
                  if (len == 16'd0) begin
                     units_upd = units_dec;
                     phase_upd = loop_top(unit_kind, units_dec, far_end, sps_leave);
                  end else begin
                     pay_left_upd = len;
                     phase_upd    = unit_kind ? PH_PPS_PAY : PH_SPS_PAY;
                  end
               end
            end
            PH_SPS_PAY, PH_PPS_PAY: begin
               pay_left_upd = pay_dec;
               if (pay_dec == 16'd0) begin
                  units_upd = units_dec;
                  phase_upd = loop_top(unit_kind, units_dec, far_end, sps_leave);
               end
            end
            default: begin
            end
         endcase
      end

      // Last byte closes the record: return to the start
      if (req_data.last_byte) begin
         pos_in      = 16'd0;
         phase_in    = PH_HEADER;
         units_in    = 8'd0;
         len_hi_in   = 8'd0;
         pay_left_in = 16'd0;
         seen_in     = 1'b0;
         rstatus_in  = STATUS_UNITS_FOUND;
      end else begin
         pos_in      = (pos_ff < POSITION_MAX) ? pos_ff + 16'd1 : pos_ff;
         phase_in    = phase_upd;
         units_in    = units_upd;
         len_hi_in   = len_hi_upd;
         pay_left_in = pay_left_upd;
         seen_in     = seen_upd;
         rstatus_in  = rstatus_upd;
      end
   end

   // Result items for this byte
   always_comb begin
      burst          = '0;
      burst.kind     = unit_kind;
      burst.sc_en    = opens_unit;
      burst.sc_end   = len == 16'd0;
      burst.pay_en   = in_payload;
      burst.pay_byte = b;
      burst.pay_end  = pay_dec == 16'd0;
      burst.done_en  = req_data.last_byte;
      if (rstatus_upd != STATUS_UNITS_FOUND) begin
         burst.status = rstatus_upd;
      end else begin
         burst.status = seen_upd ? STATUS_UNITS_FOUND : STATUS_NONE_FOUND;
      end
      burst.nitems = (opens_unit ? 3'(START_CODE_BYTES) : 3'd0)
                   + (in_payload ? 3'd1 : 3'd0)
                   + (req_data.last_byte ? 3'd1 : 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= 16'd0;
         phase_ff    <= PH_HEADER;
         units_ff    <= 8'd0;
         len_hi_ff   <= 8'd0;
         pay_left_ff <= 16'd0;
         seen_ff     <= 1'b0;
         rstatus_ff  <= STATUS_UNITS_FOUND;
      end else if (accept) begin
         pos_ff      <= pos_in;
         phase_ff    <= phase_in;
         units_ff    <= units_in;
         len_hi_ff   <= len_hi_in;
         pay_left_ff <= pay_left_in;
         seen_ff     <= seen_in;
         rstatus_ff  <= rstatus_in;
      end
   end

   a_reject_has_status: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_REJECT) |-> (rstatus_ff != STATUS_UNITS_FOUND))
      else $error("reject phase without a rejection status");

   a_payload_nonzero: assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == PH_SPS_PAY) || (phase_ff == PH_PPS_PAY)) |-> (pay_left_ff != 16'd0))
      else $error("payload phase with no payload left");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.last_byte) |=> (phase_ff == PH_HEADER && pos_ff == 16'd0))
      else $error("parser did not return to the start after the last byte");

endmodule

`default_nettype wire

// ===== rtl/avcc_pse_emitter.sv =====
`timescale 1ns / 1ps
`default_nettype none

module avcc_pse_emitter (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    load,
   input  wire avcc_pse_pkg::burst_type burst,
   output logic                         busy,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output avcc_pse_pkg::rsp_type        rsp_data
);
   import avcc_pse_pkg::*;

   burst_type  burst_ff, burst_in;
   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic       take;
   logic       last_item;

   assign take      = valid_ff && !rsp_stall;
   assign last_item = idx_ff == (burst_ff.nitems - 3'd1);
   // Slot frees when the final item of the held burst leaves this cycle
   assign busy      = valid_ff && !(take && last_item);
   assign rsp_valid = valid_ff;

   always_comb begin
      burst_in = burst_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load && burst.nitems != 3'd0) begin
         burst_in = burst;
         idx_in   = 3'd0;
         valid_in = 1'b1;
      end else if (take) begin
         if (last_item) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   // Pick the current item out of the held burst
   always_comb begin
      rsp_data = '0;
      if (burst_ff.sc_en && idx_ff <= START_CODE_LAST) begin
         rsp_data.out_byte   = (idx_ff == START_CODE_LAST) ? START_CODE_TAIL : 8'h00;
         rsp_data.unit_kind  = burst_ff.kind;
         rsp_data.unit_start = idx_ff == 3'd0;
         rsp_data.unit_end   = (idx_ff == START_CODE_LAST) && burst_ff.sc_end;
      end else if (burst_ff.pay_en && idx_ff == 3'd0) begin
         rsp_data.out_byte  = burst_ff.pay_byte;
         rsp_data.unit_kind = burst_ff.kind;
         rsp_data.unit_end  = burst_ff.pay_end;
      end else if (burst_ff.done_en) begin
         rsp_data.record_done = 1'b1;
         rsp_data.status      = burst_ff.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      burst_ff <= burst_in;
   end

   a_idx_in_burst: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (idx_ff < burst_ff.nitems))
      else $error("item index beyond burst length");

   a_no_mixed_burst: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> !(burst_ff.sc_en && burst_ff.pay_en))
      else $error("burst holds both a start code and a payload byte");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_data.record_done) |-> last_item)
      else $error("status item is not the final item of its burst");

endmodule

`default_nettype wire

// ===== rtl/avcc_parameter_set_extractor_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// avcC parameter set extractor. Feed an H.264 decoder configuration record
// one byte per req transaction, with last_byte set on its final byte; the
// block returns the sequence and picture parameter sets as Annex B units
// (00 00 00 01 start code, then payload) as rsp transactions, and closes
// every record with one status transaction (record_done set). Program the
// record length through csr_wr_en / csr_wr_data before the record starts.
// Rate: one byte per cycle, while rsp_stall is low, for every byte that
// raises at most one result transaction. The byte that completes a unit's
// length field opens a start code: four result transactions (five when it is
// also the last byte), and the input stalls until all but the last have left
// the result register; a payload byte flagged last raises two and stalls the
// input likewise. The figure is set by the single result register, which
// hands out one transaction per cycle. There is no clearing pass after reset.
module avcc_parameter_set_extractor_top (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire avcc_pse_pkg::req_type  req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output avcc_pse_pkg::rsp_type       rsp_data,
   input  wire logic                   csr_wr_en,
   input  wire logic [15:0]            csr_wr_data
);
   import avcc_pse_pkg::*;

   logic [15:0] record_bytes_ff, record_bytes_in;
   logic        req_accept;
   logic        emit_busy;
   burst_type   burst;

   // Hold the record length until software rewrites it
   assign record_bytes_in = csr_wr_en ? csr_wr_data : record_bytes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         record_bytes_ff <= 16'd0;
      end else begin
         record_bytes_ff <= record_bytes_in;
      end
   end

   // Stall the input only while the result register still has items to hand
   // out after this cycle
   assign req_stall  = emit_busy;
   assign req_accept = req_valid && !req_stall;

   avcc_pse_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .req_data     (req_data),
      .record_bytes (record_bytes_ff),
      .burst        (burst)
   );

   avcc_pse_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .load      (req_accept),
      .burst     (burst),
      .busy      (emit_busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
